[rtl/core/csc_pkg.sv]
// Shared types, constants and helper functions for the color space converter.
package csc_pkg;

  localparam int CH_BITS = 8;
  localparam int CH_MAX  = (1 << CH_BITS) - 1;
  localparam int CH_HALF = 1 << (CH_BITS - 1);

  localparam int HUE_WRAP = 360;
  localparam int SECTOR   = 60;
  localparam int HUE_FULL = SECTOR * CH_MAX;

  // Reciprocals for division by constants: q0 = (x * R) >> K, then one correction.
  localparam int R_CH   = 65793;    // floor(2^24 / 255)
  localparam int K_CH   = 24;
  localparam int R_FULL = 8982938;  // floor(2^37 / 15300)
  localparam int K_FULL = 37;

  // Restoring divider geometry for the HSV hue and saturation quotients.
  localparam int DIV_NUM_W = 17;
  localparam int DIV_DEN_W = 8;
  localparam int DIV_Q_W   = 9;

  typedef enum logic [1:0] {
    MODE_HSV2RGB = 2'd0,
    MODE_RGB2HSV = 2'd1,
    MODE_RGB2YUV = 2'd2,
    MODE_YUV2RGB = 2'd3
  } mode_t;

  // Result waiting for the divider to catch up.
  typedef struct packed {
    logic       use_div;
    logic [8:0] f0;
    logic [7:0] f1;
    logic [7:0] f2;
  } side_t;

  function automatic logic [7:0] clamp9(input logic signed [8:0] x);
    return x[8] ? 8'd0 : x[7:0];
  endfunction

  function automatic logic [7:0] clamp11(input logic signed [10:0] x);
    logic [7:0] res;
    if (x[10]) res = 8'd0;
    else if (|x[9:8]) res = 8'(CH_MAX);
    else res = x[7:0];
    return res;
  endfunction

  function automatic logic [7:0] clamp_u9(input logic [8:0] x);
    return x[8] ? 8'(CH_MAX) : x[7:0];
  endfunction

  // Q16 matrix coefficients; inv selects YUV to RGB.
  function automatic logic signed [18:0] coef(input logic inv, input logic [1:0] k,
                                              input logic [1:0] j);
    logic signed [18:0] c;
    unique case ({inv, k, j})
      5'b0_00_00: c = 19'sd19595;
      5'b0_00_01: c = 19'sd38470;
      5'b0_00_10: c = 19'sd7471;
      5'b0_01_00: c = -19'sd11003;
      5'b0_01_01: c = -19'sd21758;
      5'b0_01_10: c = 19'sd32768;
      5'b0_10_00: c = 19'sd32768;
      5'b0_10_01: c = -19'sd27453;
      5'b0_10_10: c = -19'sd5312;
      5'b1_00_00: c = 19'sd65536;
      5'b1_00_10: c = 19'sd74711;
      5'b1_01_00: c = 19'sd65536;
      5'b1_01_01: c = -19'sd25887;
      5'b1_01_10: c = -19'sd38076;
      5'b1_10_00: c = 19'sd65536;
      5'b1_10_01: c = 19'sd133169;
      default:    c = 19'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [31:0] coef_offset(input logic inv, input logic [1:0] k);
    return (!inv && k != 2'd0) ? 32'(CH_HALF * 65536) : 32'sd0;
  endfunction

  // Q16 sum to channel: floor, then clamp.
  function automatic logic [7:0] q16ch(input logic signed [31:0] acc);
    logic [7:0] res;
    if (acc[31]) res = 8'd0;
    else if (|acc[30:24]) res = 8'(CH_MAX);
    else res = acc[23:16];
    return res;
  endfunction

endpackage

[rtl/core/csc_divider.sv]
// Pipelined restoring divider, one quotient bit per stage.
module csc_divider (
  input  logic                          clk,
  input  logic                          en,
  input  logic [csc_pkg::DIV_NUM_W-1:0] num,
  input  logic [csc_pkg::DIV_DEN_W-1:0] den,
  output logic [csc_pkg::DIV_Q_W-1:0]   quo
);

  logic [csc_pkg::DIV_NUM_W-1:0] rem_q [csc_pkg::DIV_Q_W-1];
  logic [csc_pkg::DIV_DEN_W-1:0] den_q [csc_pkg::DIV_Q_W-1];
  logic [csc_pkg::DIV_Q_W-1:0]   quo_q [csc_pkg::DIV_Q_W];

  for (genvar i = 0; i < csc_pkg::DIV_Q_W; i++) begin : g_stage
    logic [csc_pkg::DIV_NUM_W-1:0] r_in;
    logic [csc_pkg::DIV_DEN_W-1:0] d_in;
    logic [csc_pkg::DIV_Q_W-1:0]   q_in;
    logic [csc_pkg::DIV_NUM_W:0]   trial;

    if (i == 0) begin : g_first
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_q[i-1];
      assign d_in = den_q[i-1];
      assign q_in = quo_q[i-1];
    end

    assign trial = {1'b0, r_in}
                 - ((csc_pkg::DIV_NUM_W + 1)'(d_in) << (csc_pkg::DIV_Q_W - 1 - i));

    always_ff @(posedge clk) begin
      if (en) begin
        quo_q[i] <= q_in
                  | (csc_pkg::DIV_Q_W'(!trial[csc_pkg::DIV_NUM_W])
                     << (csc_pkg::DIV_Q_W - 1 - i));
      end
    end

    if (i < csc_pkg::DIV_Q_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[i] <= trial[csc_pkg::DIV_NUM_W] ? r_in : trial[csc_pkg::DIV_NUM_W-1:0];
          den_q[i] <= d_in;
        end
      end
    end
  end

  assign quo = quo_q[csc_pkg::DIV_Q_W-1];

endmodule

[rtl/core/color_space_converter.sv]
// Color space converter top level: HSV/RGB/YUV conversions in a 13-stage pipeline.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------
//   cfg     | in        | cfg_we             | cfg_wdata (mode)
//   in      | in        | in_valid/in_ready  | in_first, in_second, in_third
//   out     | out       | out_valid/out_ready| out_first, out_second, out_third
//
// One transaction per cycle sustained while the output is not held; out_valid for a
// result rises at the last of 13 register stages, the first of which captures its input.
// The depth comes from the nine-stage hue and saturation
// divider used in RGB to HSV mode; all other modes are delayed to match.
// Reset clears the valid bits and sets mode to HSV to RGB.
// When out_ready is low with a result pending, every stage holds, in_ready drops.
module color_space_converter (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [10:0] in_first,
  input  logic signed [8:0]  in_second,
  input  logic signed [8:0]  in_third,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [8:0]        out_first,
  output logic [7:0]        out_second,
  output logic [7:0]        out_third
);

  csc_pkg::mode_t mode;
  logic           en;
  logic [13:1]    vld;

  // Global advance: the whole pipe moves unless the output is held.
  assign en        = !vld[13] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[13];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= csc_pkg::MODE_HSV2RGB;
    end else if (cfg_we) begin
      mode <= csc_pkg::mode_t'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[12:1], in_valid};
    end
  end

  // ---------------- stage 1: hue wrap, channel clamps, matrix inputs
  logic [9:0] h_abs;
  logic [8:0] h_mod;
  logic       inv_in;

  assign h_abs  = in_first[10] ? 10'd0 : in_first[9:0];
  assign inv_in = (mode == csc_pkg::MODE_YUV2RGB);

  always_comb begin
    if (h_abs >= 10'(2 * csc_pkg::HUE_WRAP)) h_mod = 9'(h_abs - 10'(2 * csc_pkg::HUE_WRAP));
    else if (h_abs >= 10'(csc_pkg::HUE_WRAP)) h_mod = 9'(h_abs - 10'(csc_pkg::HUE_WRAP));
    else h_mod = h_abs[8:0];
  end

  csc_pkg::mode_t           mode_q [1:6];
  logic [8:0]               h1;
  logic signed [8:0]        sat1;
  logic [7:0]               val1, r1, g1, b1;
  logic signed [10:0]       x1 [3];

  // ---------------- stage 2: sector split, min/max, matrix products
  logic [2:0] sec_c;
  logic [8:0] base_c;
  logic [7:0] mn_c, mx_c;

  always_comb begin
    priority if (h1 >= 9'(5 * csc_pkg::SECTOR)) begin
      sec_c = 3'd5; base_c = 9'(5 * csc_pkg::SECTOR);
    end else if (h1 >= 9'(4 * csc_pkg::SECTOR)) begin
      sec_c = 3'd4; base_c = 9'(4 * csc_pkg::SECTOR);
    end else if (h1 >= 9'(3 * csc_pkg::SECTOR)) begin
      sec_c = 3'd3; base_c = 9'(3 * csc_pkg::SECTOR);
    end else if (h1 >= 9'(2 * csc_pkg::SECTOR)) begin
      sec_c = 3'd2; base_c = 9'(2 * csc_pkg::SECTOR);
    end else if (h1 >= 9'(csc_pkg::SECTOR)) begin
      sec_c = 3'd1; base_c = 9'(csc_pkg::SECTOR);
    end else begin
      sec_c = 3'd0; base_c = 9'd0;
    end
  end

  always_comb begin
    mn_c = (r1 < g1) ? r1 : g1;
    mn_c = (mn_c < b1) ? mn_c : b1;
    mx_c = (r1 > g1) ? r1 : g1;
    mx_c = (mx_c > b1) ? mx_c : b1;
  end

  logic [2:0]         sec2;
  logic [5:0]         f2;
  logic signed [8:0]  sat2;
  logic [7:0]         val2, mn2, mx2, r2, g2, b2;
  logic               rmin2, gmin2;
  logic signed [29:0] prod2 [3][3];

  // ---------------- stage 3: p numerator, s*f terms, hue and saturation numerators, matrix sums
  logic signed [9:0]  omsat_c;
  logic [6:0]         omf_c;
  logic [7:0]         d_c;
  logic signed [18:0] rs_c, gs_c, bs_c, ds_c, num_c;
  logic signed [31:0] acc_c [3];

  assign omsat_c = 10'(csc_pkg::CH_MAX) - 10'(sat2);
  assign omf_c   = 7'(csc_pkg::SECTOR) - 7'(f2);
  assign d_c     = mx2 - mn2;
  assign rs_c    = $signed(19'(r2));
  assign gs_c    = $signed(19'(g2));
  assign bs_c    = $signed(19'(b2));
  assign ds_c    = $signed(19'(d_c));

  // Min-based hue: red tested first as the minimum, then green.
  always_comb begin
    priority if (rmin2) num_c = 19'sd180 * ds_c - 19'sd60 * (gs_c - bs_c);
    else if (gmin2) num_c = 19'sd300 * ds_c - 19'sd60 * (bs_c - rs_c);
    else num_c = 19'sd60 * ds_c - 19'sd60 * (rs_c - gs_c);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc_c[k] = 32'(prod2[k][0]) + 32'(prod2[k][1]) + 32'(prod2[k][2])
               + csc_pkg::coef_offset(mode_q[2] == csc_pkg::MODE_YUV2RGB, 2'(k));
    end
  end

  logic [16:0]        pnum3;
  logic signed [15:0] sf3, s60f3;
  logic [7:0]         val3, d3, mx3;
  logic [2:0]         sec3;
  logic [16:0]        hnum3, snum3;
  logic               dz3;
  logic signed [31:0] acc3 [3];

  // ---------------- divider for hue and saturation (stages 4..12)
  logic [8:0] hue_quo, sat_quo;

  csc_divider u_hue_div (
    .clk (clk),
    .en  (en),
    .num (hnum3),
    .den (d3),
    .quo (hue_quo)
  );

  csc_divider u_sat_div (
    .clk (clk),
    .en  (en),
    .num (snum3),
    .den (mx3),
    .quo (sat_quo)
  );

  // ---------------- stage 4: q and t numerators, matrix clamp
  logic signed [16:0] omq_c, omt_c;

  assign omq_c = 17'(csc_pkg::HUE_FULL) - 17'(sf3);
  assign omt_c = 17'(csc_pkg::HUE_FULL) - 17'(s60f3);

  logic [16:0]      pnum4;
  logic [22:0]      qnum4, tnum4;
  logic [7:0]       val4, mx4;
  logic [2:0]       sec4;
  logic             dz4;
  logic [2:0][7:0]  mtx4;

  // ---------------- stage 5: reciprocal multiply
  logic [33:0] pq_c;
  logic [46:0] qq_c, tq_c;

  assign pq_c = 34'(pnum4) * 34'(csc_pkg::R_CH);
  assign qq_c = 47'(qnum4) * 47'(csc_pkg::R_FULL);
  assign tq_c = 47'(tnum4) * 47'(csc_pkg::R_FULL);

  logic [16:0]      pnum5;
  logic [22:0]      qnum5, tnum5;
  logic [8:0]       pq5, qq5, tq5;
  logic [7:0]       val5, mx5;
  logic [2:0]       sec5;
  logic             dz5;
  logic [2:0][7:0]  mtx5;

  // ---------------- stage 6: quotient correction
  logic [16:0] prem_c;
  logic [22:0] qrem_c, trem_c;

  assign prem_c = pnum5 - 17'(pq5) * 17'(csc_pkg::CH_MAX);
  assign qrem_c = qnum5 - 23'(qq5) * 23'(csc_pkg::HUE_FULL);
  assign trem_c = tnum5 - 23'(tq5) * 23'(csc_pkg::HUE_FULL);

  logic [8:0]       p6, q6, t6;
  logic [7:0]       val6, mx6;
  logic [2:0]       sec6;
  logic             dz6;
  logic [2:0][7:0]  mtx6;

  // ---------------- stage 7: sector select and result merge
  csc_pkg::side_t side_c;
  logic [7:0]     pc, qc, tc;

  assign pc = csc_pkg::clamp_u9(p6);
  assign qc = csc_pkg::clamp_u9(q6);
  assign tc = csc_pkg::clamp_u9(t6);

  always_comb begin
    side_c = '0;
    unique case (mode_q[6])
      csc_pkg::MODE_HSV2RGB: begin
        unique case (sec6)
          3'd0: begin side_c.f0 = {1'b0, val6}; side_c.f1 = tc; side_c.f2 = pc; end
          3'd1: begin side_c.f0 = {1'b0, qc}; side_c.f1 = val6; side_c.f2 = pc; end
          3'd2: begin side_c.f0 = {1'b0, pc}; side_c.f1 = val6; side_c.f2 = tc; end
          3'd3: begin side_c.f0 = {1'b0, pc}; side_c.f1 = qc; side_c.f2 = val6; end
          3'd4: begin side_c.f0 = {1'b0, tc}; side_c.f1 = pc; side_c.f2 = val6; end
          default: begin side_c.f0 = {1'b0, val6}; side_c.f1 = pc; side_c.f2 = qc; end
        endcase
      end
      csc_pkg::MODE_RGB2HSV: begin
        // Grey input: hue and saturation stay zero.
        side_c.use_div = !dz6;
        side_c.f2      = mx6;
      end
      default: begin
        side_c.f0 = {1'b0, mtx6[0]};
        side_c.f1 = mtx6[1];
        side_c.f2 = mtx6[2];
      end
    endcase
  end

  csc_pkg::side_t side_q [7:12];

  // ---------------- data registers, all held on a stall
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      mode_q[1] <= mode;
      h1        <= h_mod;
      sat1      <= in_second;
      val1      <= csc_pkg::clamp9(in_third);
      r1        <= csc_pkg::clamp11(in_first);
      g1        <= csc_pkg::clamp9(in_second);
      b1        <= csc_pkg::clamp9(in_third);
      x1[0]     <= inv_in ? in_first : $signed({3'b000, csc_pkg::clamp11(in_first)});
      x1[1]     <= inv_in ? 11'(in_second) : $signed({3'b000, csc_pkg::clamp9(in_second)});
      x1[2]     <= inv_in ? 11'(in_third) : $signed({3'b000, csc_pkg::clamp9(in_third)});
      // stage 2
      mode_q[2] <= mode_q[1];
      sec2      <= sec_c;
      f2        <= 6'(h1 - base_c);
      sat2      <= sat1;
      val2      <= val1;
      mn2       <= mn_c;
      mx2       <= mx_c;
      r2        <= r1;
      g2        <= g1;
      b2        <= b1;
      rmin2     <= (r1 == mn_c);
      gmin2     <= (g1 == mn_c);
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          prod2[k][j] <= 30'(x1[j])
                       * 30'(csc_pkg::coef(mode_q[1] == csc_pkg::MODE_YUV2RGB,
                                           2'(k), 2'(j)));
        end
      end
      // stage 3
      mode_q[3] <= mode_q[2];
      pnum3     <= 17'(val2) * 17'(omsat_c[8:0]);
      sf3       <= 16'(sat2) * 16'($signed({1'b0, f2}));
      s60f3     <= 16'(sat2) * 16'($signed({1'b0, omf_c}));
      val3      <= val2;
      sec3      <= sec2;
      hnum3     <= num_c[16:0];
      d3        <= d_c;
      snum3     <= 17'(d_c) * 17'(csc_pkg::CH_MAX);
      mx3       <= mx2;
      dz3       <= (d_c == 8'd0);
      for (int k = 0; k < 3; k++) acc3[k] <= acc_c[k];
      // stage 4
      mode_q[4] <= mode_q[3];
      pnum4     <= pnum3;
      qnum4     <= 23'(val3) * 23'(omq_c[14:0]);
      tnum4     <= 23'(val3) * 23'(omt_c[14:0]);
      val4      <= val3;
      sec4      <= sec3;
      mx4       <= mx3;
      dz4       <= dz3;
      for (int k = 0; k < 3; k++) mtx4[k] <= csc_pkg::q16ch(acc3[k]);
      // stage 5
      mode_q[5] <= mode_q[4];
      pnum5     <= pnum4;
      qnum5     <= qnum4;
      tnum5     <= tnum4;
      pq5       <= pq_c[csc_pkg::K_CH+8:csc_pkg::K_CH];
      qq5       <= qq_c[csc_pkg::K_FULL+8:csc_pkg::K_FULL];
      tq5       <= tq_c[csc_pkg::K_FULL+8:csc_pkg::K_FULL];
      val5      <= val4;
      sec5      <= sec4;
      mx5       <= mx4;
      dz5       <= dz4;
      mtx5      <= mtx4;
      // stage 6
      mode_q[6] <= mode_q[5];
      p6        <= (prem_c >= 17'(csc_pkg::CH_MAX)) ? pq5 + 9'd1 : pq5;
      q6        <= (qrem_c >= 23'(csc_pkg::HUE_FULL)) ? qq5 + 9'd1 : qq5;
      t6        <= (trem_c >= 23'(csc_pkg::HUE_FULL)) ? tq5 + 9'd1 : tq5;
      val6      <= val5;
      sec6      <= sec5;
      mx6       <= mx5;
      dz6       <= dz5;
      mtx6      <= mtx5;
      // stages 7..12: wait for the divider
      side_q[7] <= side_c;
      for (int s = 8; s <= 12; s++) side_q[s] <= side_q[s-1];
      // stage 13: output register
      if (side_q[12].use_div) begin
        out_first  <= hue_quo;
        out_second <= sat_quo[7:0];
      end else begin
        out_first  <= side_q[12].f0;
        out_second <= side_q[12].f1;
      end
      out_third <= side_q[12].f2;
    end
  end

  // ---------------- checks
  a_stall_only_when_held: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a held output");

  a_sat_fits: assert property (@(posedge clk) disable iff (rst)
    (vld[12] && side_q[12].use_div) |-> (sat_quo[8] == 1'b0))
    else $error("saturation quotient overflow");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    (vld[12] && side_q[12].use_div) |-> (hue_quo <= 9'(csc_pkg::HUE_WRAP)))
    else $error("hue quotient out of range");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (en && vld[12]) |=> out_valid)
    else $error("transaction lost at output stage");

endmodule

[verif/testbench.sv]
// Self-checking testbench for the color space converter.
`timescale 1ns / 1ps

module testbench;

  localparam int IDLE_MAX   = 17;
  localparam int LATENCY    = 13;
  localparam int STALL_LONG = 120;
  localparam int WDOG_LIMIT = 4000;

  typedef struct packed {
    logic signed [10:0] first;
    logic signed [8:0]  second;
    logic signed [8:0]  third;
  } pixel_t;

  typedef struct packed {
    logic [8:0] first;
    logic [7:0] second;
    logic [7:0] third;
  } color_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_wdata = 2'd0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [10:0] in_first = '0;
  logic signed [8:0] in_second = '0;
  logic signed [8:0] in_third = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [8:0] out_first;
  logic [7:0] out_second;
  logic [7:0] out_third;

  color_space_converter i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_first(in_first), .in_second(in_second), .in_third(in_third),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_first(out_first), .out_second(out_second), .out_third(out_third)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Testbench copy of the mode register; updated once the DUT has taken the write.
  csc_pkg::mode_t conv_mode = csc_pkg::MODE_HSV2RGB;
  pixel_t pixel_queue[$];
  color_t expected_colors[$];
  int     errors = 0;
  bit     hold_output = 1'b0;  // forced long receiver stall
  bit     feed_paused = 1'b0;  // sender pause while draining

  function automatic longint clamp_ch(longint x);
    if (x < 0) return 0;
    if (x > csc_pkg::CH_MAX) return csc_pkg::CH_MAX;
    return x;
  endfunction

  function automatic longint q16_to_ch(longint acc);
    if (acc < 0) return 0;
    return clamp_ch(acc / 65536);
  endfunction

  // Predicts the converted triple for one pixel in the current mode.
  function automatic color_t convert_pixel(csc_pkg::mode_t m, pixel_t px);
    longint a, b, c, r, g, bl, mn, mx, d, num, sec, f, p, q, t, full;
    longint o0, o1, o2;
    color_t res;
    a = px.first;
    b = px.second;
    c = px.third;
    full = 60 * csc_pkg::CH_MAX;
    case (m)
      csc_pkg::MODE_HSV2RGB: begin
        if (a < 0) a = 0;
        a = a % 360;
        if (b == 0) begin
          o0 = c; o1 = c; o2 = c;
        end else begin
          sec = a / 60;
          f = a % 60;
          p = c * (csc_pkg::CH_MAX - b) / csc_pkg::CH_MAX;
          q = c * (full - b * f) / full;
          t = c * (full - b * (60 - f)) / full;
          case (sec)
            0: begin o0 = c; o1 = t; o2 = p; end
            1: begin o0 = q; o1 = c; o2 = p; end
            2: begin o0 = p; o1 = c; o2 = t; end
            3: begin o0 = p; o1 = q; o2 = c; end
            4: begin o0 = t; o1 = p; o2 = c; end
            default: begin o0 = c; o1 = p; o2 = q; end
          endcase
        end
        o0 = clamp_ch(o0); o1 = clamp_ch(o1); o2 = clamp_ch(o2);
      end
      csc_pkg::MODE_RGB2HSV: begin
        r = clamp_ch(a); g = clamp_ch(b); bl = clamp_ch(c);
        mn = (r < g) ? r : g;
        mn = (mn < bl) ? mn : bl;
        mx = (r > g) ? r : g;
        mx = (mx > bl) ? mx : bl;
        d = mx - mn;
        o2 = mx;
        if (d == 0) begin
          o0 = 0; o1 = 0;
        end else begin
          o1 = d * csc_pkg::CH_MAX / mx;
          if (r == mn) num = 180 * d - 60 * (g - bl);
          else if (g == mn) num = 300 * d - 60 * (bl - r);
          else num = 60 * d - 60 * (r - g);
          o0 = num / d;
        end
      end
      csc_pkg::MODE_RGB2YUV: begin
        r = clamp_ch(a); g = clamp_ch(b); bl = clamp_ch(c);
        o0 = q16_to_ch(19595 * r + 38470 * g + 7471 * bl);
        o1 = q16_to_ch(-11003 * r - 21758 * g + 32768 * bl + csc_pkg::CH_HALF * 65536);
        o2 = q16_to_ch(32768 * r - 27453 * g - 5312 * bl + csc_pkg::CH_HALF * 65536);
      end
      default: begin
        o0 = q16_to_ch(a * 65536 + 74711 * c);
        o1 = q16_to_ch(a * 65536 - 25887 * b - 38076 * c);
        o2 = q16_to_ch(a * 65536 + 133169 * b);
      end
    endcase
    res.first = o0[8:0];
    res.second = o1[7:0];
    res.third = o2[7:0];
    return res;
  endfunction

  function automatic pixel_t make_pixel(int f, int s, int t);
    pixel_t px;
    px.first = f[10:0];
    px.second = s[8:0];
    px.third = t[8:0];
    return px;
  endfunction

  // Random pixel: mostly in-range channel values, some wide-range noise.
  function automatic pixel_t random_pixel(csc_pkg::mode_t m);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0)
      return make_pixel($urandom_range(0, 2047) - 1024, $urandom_range(0, 383) - 128,
                        $urandom_range(0, 383) - 128);
    case (m)
      csc_pkg::MODE_HSV2RGB: return make_pixel($urandom_range(0, 719),
                                               $urandom_range(0, 255),
                                               $urandom_range(0, 255));
      csc_pkg::MODE_YUV2RGB: return make_pixel($urandom_range(0, 255),
                                               $urandom_range(0, 255) - 128,
                                               $urandom_range(0, 255) - 128);
      default: begin
        if (sel == 1)  // grey or tied channels
          return make_pixel(sel * 0 + 77, 77, $urandom_range(0, 1) ? 77 : 200);
        return make_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255));
      end
    endcase
  endfunction

  // Driver: one pixel per transaction, random gap drawn per item.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_colors.push_back(convert_pixel(conv_mode, pixel_queue.pop_front()));
        send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, IDLE_MAX) : 0;
      end
      if (!in_valid || in_ready) begin
        if (in_valid && in_ready && pixel_queue.size() > 0 && send_gap == 0 &&
            !feed_paused && $urandom_range(0, 3) != 0) begin
          // back-to-back: keep valid high with the next pixel
          in_first <= pixel_queue[0].first;
          in_second <= pixel_queue[0].second;
          in_third <= pixel_queue[0].third;
        end else if (!(in_valid && in_ready) && pixel_queue.size() > 0 && send_gap == 0 &&
                     !feed_paused) begin
          in_valid <= 1'b1;
          in_first <= pixel_queue[0].first;
          in_second <= pixel_queue[0].second;
          in_third <= pixel_queue[0].third;
        end else begin
          in_valid <= 1'b0;
          if (send_gap > 0 && !(in_valid && in_ready)) send_gap <= send_gap - 1;
        end
      end
    end
  end

  // Monitor: compares each result transaction with the oldest prediction.
  int recv_gap = 0;
  always @(posedge clk) begin
    color_t exp_c;
    int     gap;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_colors.size() == 0) begin
          $error("unexpected result %0d %0d %0d", out_first, out_second, out_third);
          errors++;
        end else begin
          exp_c = expected_colors.pop_front();
          if (out_first !== exp_c.first) begin
            $error("out_first expected %0d actual %0d", exp_c.first, out_first);
            errors++;
          end
          if (out_second !== exp_c.second) begin
            $error("out_second expected %0d actual %0d", exp_c.second, out_second);
            errors++;
          end
          if (out_third !== exp_c.third) begin
            $error("out_third expected %0d actual %0d", exp_c.third, out_third);
            errors++;
          end
        end
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, IDLE_MAX) : 0;
        recv_gap <= gap;
        out_ready <= (gap == 0) && !hold_output;
      end else if (hold_output) begin
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no transaction on either side.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic drain();
    while (pixel_queue.size() > 0 || in_valid || expected_colors.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic set_mode(csc_pkg::mode_t m);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    conv_mode = m;
  endtask

  // Long receiver stall while the sender keeps offering pixels.
  initial begin
    wait (!rst);
    while (pixel_queue.size() < 60) @(posedge clk);
    hold_output = 1'b1;
    repeat (STALL_LONG) @(posedge clk);
    hold_output = 1'b0;
  end

  initial begin
    csc_pkg::mode_t modes[4];
    int    n;
    modes = '{csc_pkg::MODE_HSV2RGB, csc_pkg::MODE_RGB2HSV, csc_pkg::MODE_RGB2YUV,
              csc_pkg::MODE_YUV2RGB};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset mode is HSV to RGB: hue wrap, negative hue, grey, out-of-range s/v.
    pixel_queue.push_back(make_pixel(-1024, 255, 255));
    pixel_queue.push_back(make_pixel(1023, 255, 255));
    pixel_queue.push_back(make_pixel(360, 200, 200));
    pixel_queue.push_back(make_pixel(359, 255, 255));
    pixel_queue.push_back(make_pixel(120, 0, 255));
    pixel_queue.push_back(make_pixel(200, 0, -128));
    pixel_queue.push_back(make_pixel(250, -128, 255));
    pixel_queue.push_back(make_pixel(300, 255, -128));
    drain();
    set_mode(csc_pkg::MODE_RGB2HSV);  // pure red, equal channels, ties, clamp
    pixel_queue.push_back(make_pixel(255, 0, 0));
    pixel_queue.push_back(make_pixel(90, 90, 90));
    pixel_queue.push_back(make_pixel(0, 0, 255));
    pixel_queue.push_back(make_pixel(0, 255, 255));
    pixel_queue.push_back(make_pixel(1023, -128, 0));
    drain();
    set_mode(csc_pkg::MODE_RGB2YUV);
    pixel_queue.push_back(make_pixel(255, 255, 255));
    pixel_queue.push_back(make_pixel(-1024, 255, -128));
    pixel_queue.push_back(make_pixel(0, 0, 255));
    drain();
    set_mode(csc_pkg::MODE_YUV2RGB);
    pixel_queue.push_back(make_pixel(1023, 255, 255));
    pixel_queue.push_back(make_pixel(-1024, -128, -128));
    pixel_queue.push_back(make_pixel(128, 127, -128));
    pixel_queue.push_back(make_pixel(0, -1, -1));
    drain();

    // Random phases across all modes, extremes included.
    for (int ph = 0; ph < 12; ph++) begin
      set_mode(modes[(ph < 4) ? ph : $urandom_range(0, 3)]);
      n = $urandom_range(100, 160);
      for (int k = 0; k < n; k++) pixel_queue.push_back(random_pixel(conv_mode));
      if (ph == 6) begin
        // sender pauses mid-phase until all results are back
        while (pixel_queue.size() > n / 2) @(posedge clk);
        feed_paused = 1'b1;
        while (in_valid || expected_colors.size() > 0) @(posedge clk);
        feed_paused = 1'b0;
      end
      drain();
    end

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
